// ===== rtl/core/bitstuffed_tile_dequantizer_unit_defines.svh =====
// assertion macros for the bit-stuffed tile dequantizer
// no dependencies; included by the top level only
`ifndef BITSTUFFED_TILE_DEQUANTIZER_UNIT_DEFINES_SVH
`define BITSTUFFED_TILE_DEQUANTIZER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BTDQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("btdq same-cycle check failed");
`define BTDQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("btdq next-cycle check failed");
`else
`define BTDQ_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define BTDQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/btdq_pkg.sv =====
// shared types and constants for the bit-stuffed tile dequantizer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package btdq_pkg;

    localparam int unsigned WordBits         = 32;
    localparam int unsigned DualWordBits     = 2 * WordBits;
    localparam int unsigned CodeBits         = 31;
    localparam int unsigned WidthBits        = 5;
    localparam int unsigned TileElemBits     = 24;
    localparam int unsigned CfgIndexBits     = 3;
    localparam int unsigned PtrBits          = 7;
    localparam int unsigned CountBitsDefault = 24;
    localparam int unsigned QueueDepth       = 2;

    localparam logic [WidthBits-1:0] BitsReset = 5'd1;
    localparam logic [WordBits-1:0]  ZMaxReset = 32'h7FFF_FFFF;
    localparam logic [WordBits-1:0]  SatMax    = 32'h7FFF_FFFF;

    typedef enum logic [CfgIndexBits-1:0] {
        REG_BITS_PER_VALUE = 3'd0,
        REG_TILE_ELEMENTS  = 3'd1,
        REG_Z_OFFSET       = 3'd2,
        REG_Z_STEP         = 3'd3,
        REG_Z_MAX          = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [WordBits-1:0] word;
        logic                first;
    } entry_t;

    typedef struct packed {
        logic [CodeBits-1:0] code;
        logic                last;
    } code_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic busy;
        logic elements_zero;
    } back_status_t;

endpackage

// ===== rtl/core/btdq_front.sv =====
// front end: accepts packed words, tracks tile words, applies the tail shift
// depends on btdq_pkg
`timescale 1ns / 1ps

module btdq_front #(
    parameter int unsigned COUNT_BITS = btdq_pkg::CountBitsDefault
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   clear,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [btdq_pkg::WordBits-1:0]          s_packed_word,
    input  logic [btdq_pkg::WidthBits-1:0]         width,
    input  logic [btdq_pkg::TileElemBits-1:0]      tile_elements,
    input  btdq_pkg::queue_status_t                queue_status,
    output logic                                   push,
    output btdq_pkg::entry_t                       push_entry
);

    localparam int unsigned ProdBits = COUNT_BITS + btdq_pkg::WidthBits;

    logic [COUNT_BITS-1:0]             words_left_reg;
    logic [COUNT_BITS-1:0]             words_left_next;
    logic [COUNT_BITS-1:0]             elem_count;
    logic [COUNT_BITS-1:0]             words_total;
    logic [COUNT_BITS-1:0]             words_cur;
    logic [ProdBits-1:0]               total_bits;
    logic [ProdBits:0]                 rounded;
    logic [btdq_pkg::WidthBits-1:0]    tail_bits;
    logic [btdq_pkg::WidthBits-1:0]    tail_less;
    logic [1:0]                        skip_bytes;
    logic [btdq_pkg::WordBits-1:0]     shifted_word;
    logic                              start;
    logic                              drop;
    logic                              accept;

    assign elem_count  = COUNT_BITS'(tile_elements);
    assign total_bits  = ProdBits'(elem_count) * ProdBits'(width);
    assign rounded     = (ProdBits + 1)'(total_bits) + (ProdBits + 1)'(btdq_pkg::WordBits - 1);
    assign words_total = rounded[ProdBits-1:btdq_pkg::WidthBits];

    // bytes of the last word that the tile does not use
    assign tail_bits    = total_bits[btdq_pkg::WidthBits-1:0];
    assign tail_less    = tail_bits - 5'd1;
    assign skip_bytes   = (tail_bits == '0) ? 2'd0 : ~tail_less[4:3];
    assign shifted_word = s_packed_word << {skip_bytes, 3'b000};

    assign start     = (words_left_reg == '0);
    assign drop      = start && (elem_count == '0);
    assign s_ready   = !queue_status.full;
    assign accept    = s_valid && s_ready;
    assign push      = accept && !drop;
    assign words_cur = start ? words_total : words_left_reg;

    assign push_entry.word  = (words_cur == COUNT_BITS'(1)) ? shifted_word : s_packed_word;
    assign push_entry.first = start;

    always_comb begin
        words_left_next = words_left_reg;
        if (clear) begin
            words_left_next = '0;
        end else if (push) begin
            words_left_next = words_cur - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_left_reg <= '0;
        end else begin
            words_left_reg <= words_left_next;
        end
    end

endmodule

// ===== rtl/core/btdq_queue.sv =====
// short queue of classified words between front and back
// depends on btdq_pkg
`timescale 1ns / 1ps

module btdq_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    clear,
    input  logic                    push,
    input  btdq_pkg::entry_t        push_entry,
    input  logic                    pop,
    output btdq_pkg::entry_t        pop_entry,
    output btdq_pkg::queue_status_t status
);

    localparam int unsigned Depth = btdq_pkg::QueueDepth;
    localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW  = $clog2(Depth + 1);

    btdq_pkg::entry_t  mem_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == CntW'(Depth));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (clear) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end else begin
            if (do_push) begin
                wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_next = count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_next = count_reg - CntW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push && !clear) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/btdq_back.sv =====
// back end: extracts codes msb-first from the current word and the carried word
// depends on btdq_pkg
`timescale 1ns / 1ps

module btdq_back #(
    parameter int unsigned COUNT_BITS = btdq_pkg::CountBitsDefault
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               clear,
    input  logic [btdq_pkg::WidthBits-1:0]     width,
    input  logic [btdq_pkg::TileElemBits-1:0]  tile_elements,
    input  btdq_pkg::queue_status_t            queue_status,
    input  btdq_pkg::entry_t                   pop_entry,
    output logic                               pop,
    output logic                               code_valid,
    input  logic                               code_ready,
    output btdq_pkg::code_t                    code_out,
    output btdq_pkg::back_status_t             status
);

    localparam int unsigned WB  = btdq_pkg::WordBits;
    localparam int unsigned DWB = btdq_pkg::DualWordBits;
    localparam int unsigned PB  = btdq_pkg::PtrBits;
    localparam int unsigned CB  = btdq_pkg::CodeBits;

    logic                              busy_reg;
    logic                              busy_next;
    logic [DWB-1:0]                    buf_reg;
    logic [DWB-1:0]                    buf_next;
    logic [PB-1:0]                     ptr_reg;
    logic [PB-1:0]                     ptr_next;
    logic [WB-1:0]                     carry_reg;
    logic [WB-1:0]                     carry_next;
    logic [btdq_pkg::WidthBits-1:0]    bitpos_reg;
    logic [btdq_pkg::WidthBits-1:0]    bitpos_next;
    logic [COUNT_BITS-1:0]             elem_reg;
    logic [COUNT_BITS-1:0]             elem_next;

    logic [WB-1:0]                     carry_sel;
    logic [btdq_pkg::WidthBits-1:0]    pos_sel;
    logic [PB-1:0]                     shamt;
    logic [DWB-1:0]                    shifted;
    logic [CB-1:0]                     code_mask;
    logic [PB-1:0]                     ptr_adv;
    logic [PB:0]                       ptr_reach;
    logic [COUNT_BITS-1:0]             elem_dec;
    logic                              tile_done;
    logic                              word_done;
    logic                              emit;

    assign pop        = !busy_reg && !queue_status.empty;
    assign code_valid = busy_reg;
    assign emit       = busy_reg && code_ready;

    assign carry_sel = pop_entry.first ? '0 : carry_reg;
    assign pos_sel   = pop_entry.first ? '0 : bitpos_reg;

    // code sits in the top bits of the window starting at ptr
    assign shamt     = PB'(DWB) - ptr_reg - PB'(width);
    assign shifted   = buf_reg >> shamt;
    assign code_mask = (CB'(1) << width) - CB'(1);

    assign ptr_adv   = ptr_reg + PB'(width);
    assign ptr_reach = (PB + 1)'(ptr_adv) + (PB + 1)'(width);
    assign elem_dec  = elem_reg - COUNT_BITS'(1);
    assign tile_done = (elem_dec == '0);
    assign word_done = tile_done || (ptr_reach > (PB + 1)'(DWB));

    assign code_out.code = shifted[CB-1:0] & code_mask;
    assign code_out.last = tile_done;

    assign status.busy          = busy_reg;
    assign status.elements_zero = (elem_reg == '0);

    always_comb begin
        busy_next   = busy_reg;
        buf_next    = buf_reg;
        ptr_next    = ptr_reg;
        carry_next  = carry_reg;
        bitpos_next = bitpos_reg;
        elem_next   = elem_reg;
        if (clear) begin
            busy_next   = 1'b0;
            carry_next  = '0;
            bitpos_next = '0;
            elem_next   = '0;
        end else if (pop) begin
            busy_next = 1'b1;
            buf_next  = {carry_sel, pop_entry.word};
            ptr_next  = (pos_sel != '0) ? PB'(pos_sel) : PB'(WB);
            if (pop_entry.first) begin
                elem_next = COUNT_BITS'(tile_elements);
            end
        end else if (emit) begin
            elem_next = elem_dec;
            ptr_next  = ptr_adv;
            if (word_done) begin
                busy_next   = 1'b0;
                carry_next  = buf_reg[WB-1:0];
                bitpos_next = tile_done ? '0 : ptr_adv[btdq_pkg::WidthBits-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            carry_reg  <= '0;
            bitpos_reg <= '0;
            elem_reg   <= '0;
        end else begin
            busy_reg   <= busy_next;
            carry_reg  <= carry_next;
            bitpos_reg <= bitpos_next;
            elem_reg   <= elem_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        ptr_reg <= ptr_next;
    end

endmodule

// ===== rtl/core/btdq_dequant.sv =====
// dequantizer pipeline: code register, multiply, offset add with saturate and clamp
// depends on btdq_pkg
`timescale 1ns / 1ps

module btdq_dequant (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  code_valid,
    output logic                                  code_ready,
    input  btdq_pkg::code_t                       code_in,
    input  logic signed [btdq_pkg::WordBits-1:0]  z_offset,
    input  logic [btdq_pkg::WordBits-1:0]         z_step,
    input  logic signed [btdq_pkg::WordBits-1:0]  z_max,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [btdq_pkg::CodeBits-1:0]         m_code_value,
    output logic signed [btdq_pkg::WordBits-1:0]  m_height_value,
    output logic                                  m_last_of_tile
);

    localparam int unsigned WB  = btdq_pkg::WordBits;
    localparam int unsigned CB  = btdq_pkg::CodeBits;
    localparam int unsigned PRB = CB + WB;
    localparam int unsigned SB  = 2 * WB;

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    btdq_pkg::code_t         c1_reg;
    btdq_pkg::code_t         c2_reg;
    logic [PRB-1:0]          prod_reg;
    logic [CB-1:0]           code3_reg;
    logic [WB-1:0]           h3_reg;
    logic                    last3_reg;

    logic                    en1;
    logic                    en2;
    logic                    en3;
    logic [SB-1:0]           sum;
    logic                    over;
    logic [WB-1:0]           sat;
    logic [WB-1:0]           height;

    assign en3        = !v3_reg || m_ready;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign code_ready = en1;

    // product is never negative, so only the upper bound saturates
    assign sum    = {{WB{z_offset[WB-1]}}, z_offset} + SB'(prod_reg);
    assign over   = !sum[SB-1] && (sum[SB-2:WB-1] != '0);
    assign sat    = over ? btdq_pkg::SatMax : sum[WB-1:0];
    assign height = ($signed(sat) > z_max) ? z_max : sat;

    assign m_valid        = v3_reg;
    assign m_code_value   = code3_reg;
    assign m_height_value = h3_reg;
    assign m_last_of_tile = last3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= code_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            c1_reg <= code_in;
        end
        if (en2) begin
            c2_reg   <= c1_reg;
            prod_reg <= PRB'(c1_reg.code) * PRB'(z_step);
        end
        if (en3) begin
            code3_reg <= c2_reg.code;
            last3_reg <= c2_reg.last;
            h3_reg    <= height;
        end
    end

endmodule

// ===== rtl/core/bitstuffed_tile_dequantizer_unit.sv =====
// channel   | handshake               | payload
// s_ (in)   | s_valid / s_ready       | s_packed_word
// m_ (out)  | m_valid / m_ready       | m_code_value, m_height_value, m_last_of_tile
// cfg_      | cfg_valid / cfg_ready   | cfg_index, cfg_data
// the extractor loads a word, then yields one code per cycle while the dequant pipeline accepts;
// it takes no new word until the last code of the current one has left its single shift window
// a code goes from the extractor window through the code, product and height registers of the dequant pipeline
// no clearing pass after reset; the word queue decouples input from output stalls
// top level: config registers, front, queue, back and dequant pipeline
// depends on btdq_pkg and the defines header
`timescale 1ns / 1ps
`include "bitstuffed_tile_dequantizer_unit_defines.svh"

module bitstuffed_tile_dequantizer_unit #(
    parameter int unsigned COUNT_BITS = btdq_pkg::CountBitsDefault
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [btdq_pkg::WordBits-1:0]           s_packed_word,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [btdq_pkg::CodeBits-1:0]           m_code_value,
    output logic signed [btdq_pkg::WordBits-1:0]    m_height_value,
    output logic                                    m_last_of_tile,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [btdq_pkg::CfgIndexBits-1:0]       cfg_index,
    input  logic [btdq_pkg::WordBits-1:0]           cfg_data
);

    logic [btdq_pkg::WidthBits-1:0]     bits_reg;
    logic [btdq_pkg::TileElemBits-1:0]  tile_reg;
    logic signed [btdq_pkg::WordBits-1:0] offset_reg;
    logic [btdq_pkg::WordBits-1:0]      step_reg;
    logic signed [btdq_pkg::WordBits-1:0] max_reg;

    logic                               cfg_wr;
    logic                               cfg_clear;
    logic [btdq_pkg::WidthBits-1:0]     width_eff;

    logic                               push;
    btdq_pkg::entry_t                   push_entry;
    logic                               pop;
    btdq_pkg::entry_t                   pop_entry;
    btdq_pkg::queue_status_t            queue_status;
    btdq_pkg::back_status_t             back_status;
    logic                               code_valid;
    logic                               code_ready;
    btdq_pkg::code_t                    code_bus;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign width_eff = (bits_reg == '0) ? btdq_pkg::WidthBits'(1) : bits_reg;

    always_comb begin
        case (cfg_index)
            btdq_pkg::REG_BITS_PER_VALUE,
            btdq_pkg::REG_TILE_ELEMENTS,
            btdq_pkg::REG_Z_OFFSET,
            btdq_pkg::REG_Z_STEP,
            btdq_pkg::REG_Z_MAX: cfg_clear = cfg_wr;
            default:             cfg_clear = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg   <= btdq_pkg::BitsReset;
            tile_reg   <= '0;
            offset_reg <= '0;
            step_reg   <= '0;
            max_reg    <= btdq_pkg::ZMaxReset;
        end else if (cfg_wr) begin
            case (cfg_index)
                btdq_pkg::REG_BITS_PER_VALUE: bits_reg   <= cfg_data[btdq_pkg::WidthBits-1:0];
                btdq_pkg::REG_TILE_ELEMENTS:  tile_reg   <= cfg_data[btdq_pkg::TileElemBits-1:0];
                btdq_pkg::REG_Z_OFFSET:       offset_reg <= cfg_data;
                btdq_pkg::REG_Z_STEP:         step_reg   <= cfg_data;
                btdq_pkg::REG_Z_MAX:          max_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    btdq_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clear         (cfg_clear),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packed_word (s_packed_word),
        .width         (width_eff),
        .tile_elements (tile_reg),
        .queue_status  (queue_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    btdq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_clear),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (queue_status)
    );

    btdq_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clear         (cfg_clear),
        .width         (width_eff),
        .tile_elements (tile_reg),
        .queue_status  (queue_status),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .code_valid    (code_valid),
        .code_ready    (code_ready),
        .code_out      (code_bus),
        .status        (back_status)
    );

    btdq_dequant u_dequant (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .code_valid     (code_valid),
        .code_ready     (code_ready),
        .code_in        (code_bus),
        .z_offset       (offset_reg),
        .z_step         (step_reg),
        .z_max          (max_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_value   (m_code_value),
        .m_height_value (m_height_value),
        .m_last_of_tile (m_last_of_tile)
    );

    // a write to a defined register drops the tile held in front, queue and extractor
    `BTDQ_ASSERT_NEXT(a_cfg_clears, aclk, aresetn, cfg_clear, !back_status.busy && queue_status.empty)
    // extractor only works on a word while codes remain in the tile
    `BTDQ_ASSERT_IMPLY(a_busy_has_codes, aclk, aresetn, back_status.busy, !back_status.elements_zero)
    // a full queue holds off the input channel
    `BTDQ_ASSERT_IMPLY(a_full_stalls, aclk, aresetn, queue_status.full, !s_ready)

endmodule
